// ----- design/procedural_noise_texture_gen_unit_assert.svh -----
// Assertion macros for the procedural noise texture generator.
// Included by the top level; no other dependencies.
`ifndef PROCEDURAL_NOISE_TEXTURE_GEN_UNIT_ASSERT_SVH
`define PROCEDURAL_NOISE_TEXTURE_GEN_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PNTG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pntg assertion failed");
// next-cycle implication
`define PNTG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pntg assertion failed");
`else
`define PNTG_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PNTG_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/pntg_pkg.sv -----
// Shared types and constants for the procedural noise texture generator.
// No dependencies.
`timescale 1ns / 1ps

package pntg_pkg;

    localparam int STORE_AW = 16;
    localparam int TEXEL_W  = 8;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [STORE_AW-1:0] MIRROR_MASK = 16'hFF00;
    localparam logic [STORE_AW-1:0] LOOKAHEAD   = 16'd255;
    localparam logic [TEXEL_W-1:0]  SEED_RESET  = 8'hC9;

    localparam logic [1:0] MODE_GEN     = 2'd0;
    localparam logic [1:0] MODE_READ    = 2'd1;
    localparam logic [1:0] MODE_RESTART = 2'd2;

    localparam logic REG_ACCUM_SEED = 1'b0;

    // controller -> datapath
    typedef struct packed {
        logic clr_write;   // clearing pass: store[clr_addr] <= clr_addr mod 256
        logic gen_start;   // update hash, read store at step+255
        logic gen_calc;    // new accumulator, write primary texel
        logic gen_mirror;  // write mirror texel, load result, advance step
        logic rd_start;    // read store at read_index
        logic out_read;    // load result with read data
        logic out_plain;   // load result with no write and no read
        logic restart;     // reload generator state
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic done;
        logic clr_last;
        logic out_valid;
    } sts_t;

endpackage

// ----- design/pntg_datapath.sv -----
// Datapath: generator state, texture store, clearing counter and result register.
// Depends on pntg_pkg.
`timescale 1ns / 1ps

module pntg_datapath
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pntg_pkg::cmd_t                       cmd,
    input  logic [pntg_pkg::STORE_AW-1:0]        read_index,
    input  logic [pntg_pkg::TEXEL_W-1:0]         accum_seed,
    input  logic                                 out_ready,
    output pntg_pkg::sts_t                       sts,
    output logic                                 out_valid,
    output logic                                 write_valid,
    output logic [pntg_pkg::STORE_AW-1:0]        write_index,
    output logic [pntg_pkg::STORE_AW-1:0]        mirror_index,
    output logic [pntg_pkg::TEXEL_W-1:0]         texel_value,
    output logic [pntg_pkg::TEXEL_W-1:0]         read_value,
    output logic                                 finished
);

    localparam int AW = pntg_pkg::STORE_AW;
    localparam int DW = pntg_pkg::TEXEL_W;

    logic [DW-1:0] mem [0:(1<<AW)-1];

    logic [AW-1:0] hash_reg,  hash_next;
    logic [DW-1:0] acc_reg,   acc_next;
    logic [AW-1:0] step_reg,  step_next;
    logic          done_reg,  done_next;
    logic [AW-1:0] clr_reg,   clr_next;
    logic [DW-1:0] rdata_reg;
    logic          out_valid_reg;
    logic          wv_reg;
    logic [AW-1:0] wi_reg;
    logic [AW-1:0] mi_reg;
    logic [DW-1:0] tv_reg;
    logic [DW-1:0] rv_reg;
    logic          fin_reg;

    logic [AW-1:0]   hash_sum;
    logic [2*AW-1:0] hash_rot;
    logic [DW-1:0]   delta;
    logic [DW:0]     s_sum;
    logic [DW:0]     t_sum;
    logic [DW-1:0]   acc_new;
    logic [AW-1:0]   step_dec;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [DW-1:0]   mem_wdata;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;
    logic            out_load;

    // hash mix: add index, rotate left by index mod 16
    assign hash_sum = hash_reg + step_reg;
    assign hash_rot = {hash_sum, hash_sum} << step_reg[3:0];

    // accumulator walk from the hash low byte, averaged with the lookahead texel
    assign delta   = {{(DW-3){hash_reg[7]}}, hash_reg[7:5]};
    assign s_sum   = {1'b0, acc_reg} + {1'b0, delta} + {{DW{1'b0}}, hash_reg[4]};
    assign t_sum   = {1'b0, s_sum[DW-1:0]} + {1'b0, rdata_reg} + {{DW{1'b0}}, s_sum[DW]};
    assign acc_new = {1'b0, t_sum[DW-1:1]};

    assign step_dec = step_reg - {{(AW-1){1'b0}}, 1'b1};

    always_comb
    begin
        mem_we    = cmd.clr_write | cmd.gen_calc | cmd.gen_mirror;
        mem_waddr = clr_reg;
        mem_wdata = clr_reg[DW-1:0];
        if (cmd.gen_calc)
        begin
            mem_waddr = step_reg;
            mem_wdata = acc_new;
        end
        else if (cmd.gen_mirror)
        begin
            mem_waddr = step_reg ^ pntg_pkg::MIRROR_MASK;
            mem_wdata = acc_reg;
        end
        mem_re    = cmd.gen_start | cmd.rd_start;
        mem_raddr = cmd.rd_start ? read_index : (step_reg + pntg_pkg::LOOKAHEAD);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_comb
    begin
        hash_next = hash_reg;
        acc_next  = acc_reg;
        step_next = step_reg;
        done_next = done_reg;
        clr_next  = clr_reg;
        if (cmd.restart)
        begin
            hash_next = '0;
            acc_next  = accum_seed;
            step_next = '0;
            done_next = 1'b0;
            clr_next  = '0;
        end
        else
        begin
            if (cmd.clr_write)
                clr_next = clr_reg + {{(AW-1){1'b0}}, 1'b1};
            if (cmd.gen_start)
                hash_next = hash_rot[2*AW-1:AW];
            if (cmd.gen_calc)
                acc_next = acc_new;
            if (cmd.gen_mirror)
            begin
                step_next = step_dec;
                done_next = (step_dec == '0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= '0;
            acc_reg  <= pntg_pkg::SEED_RESET;
            step_reg <= '0;
            done_reg <= 1'b0;
            clr_reg  <= '0;
        end
        else
        begin
            hash_reg <= hash_next;
            acc_reg  <= acc_next;
            step_reg <= step_next;
            done_reg <= done_next;
            clr_reg  <= clr_next;
        end
    end

    // result register
    assign out_load = cmd.out_plain | cmd.out_read | cmd.gen_mirror;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            wv_reg  <= cmd.gen_mirror;
            wi_reg  <= cmd.gen_mirror ? step_reg : '0;
            mi_reg  <= cmd.gen_mirror ? (step_reg ^ pntg_pkg::MIRROR_MASK) : '0;
            tv_reg  <= cmd.gen_mirror ? acc_reg : '0;
            rv_reg  <= cmd.out_read ? rdata_reg : '0;
            fin_reg <= cmd.gen_mirror ? (step_dec == '0) :
                       (cmd.restart ? 1'b0 : done_reg);
        end
    end

    assign out_valid    = out_valid_reg;
    assign write_valid  = wv_reg;
    assign write_index  = wi_reg;
    assign mirror_index = mi_reg;
    assign texel_value  = tv_reg;
    assign read_value   = rv_reg;
    assign finished     = fin_reg;

    assign sts.done      = done_reg;
    assign sts.clr_last  = &clr_reg;
    assign sts.out_valid = out_valid_reg;

endmodule

// ----- design/pntg_ctrl.sv -----
// Controller FSM: sequences clearing pass, generate, read and restart transactions.
// Depends on pntg_pkg.
`timescale 1ns / 1ps

module pntg_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [1:0]     mode,
    input  logic           out_ready,
    input  pntg_pkg::sts_t sts,
    output logic           in_ready,
    output pntg_pkg::cmd_t cmd
);

    localparam logic [2:0] ST_CLEAR      = 3'd0;
    localparam logic [2:0] ST_IDLE       = 3'd1;
    localparam logic [2:0] ST_GEN_CALC   = 3'd2;
    localparam logic [2:0] ST_GEN_MIRROR = 3'd3;
    localparam logic [2:0] ST_READ       = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       in_fire;

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        in_fire    = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_write = 1'b1;
                if (sts.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = !sts.out_valid || out_ready;
                in_fire  = in_valid && in_ready;
                if (in_fire)
                begin
                    case (mode)
                        pntg_pkg::MODE_GEN:
                        begin
                            if (!sts.done)
                            begin
                                cmd.gen_start = 1'b1;
                                state_next    = ST_GEN_CALC;
                            end
                            else
                                cmd.out_plain = 1'b1;
                        end
                        pntg_pkg::MODE_READ:
                        begin
                            cmd.rd_start = 1'b1;
                            state_next   = ST_READ;
                        end
                        pntg_pkg::MODE_RESTART:
                        begin
                            cmd.restart   = 1'b1;
                            cmd.out_plain = 1'b1;
                            state_next    = ST_CLEAR;
                        end
                        default:
                            cmd.out_plain = 1'b1;
                    endcase
                end
            end
            ST_GEN_CALC:
            begin
                cmd.gen_calc = 1'b1;
                state_next   = ST_GEN_MIRROR;
            end
            ST_GEN_MIRROR:
            begin
                cmd.gen_mirror = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_READ:
            begin
                cmd.out_read = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

endmodule

// ----- design/procedural_noise_texture_gen_unit.sv -----
// Top level of the procedural noise texture generator: APB seed register,
// controller and datapath. Depends on pntg_pkg, pntg_ctrl, pntg_datapath.
`timescale 1ns / 1ps
`include "procedural_noise_texture_gen_unit_assert.svh"

// Usage
// - Input channel (in_valid/in_ready, mode, read_index): one transaction per
//   command. mode 0 runs one generator step (none once done), 1 reads a texel, 2 restarts.
// - Output channel (out_valid/out_ready): exactly one result transaction per
//   input transaction, in order.
// - APB register 0 (accum_seed) loads the accumulator at reset and restart.
// Sequencing: a generate step runs through the accept (gen_start), GEN_CALC and
//   GEN_MIRROR states; a texel read through accept and ST_READ; other modes load
//   the result on accept. The 65536x8 texture store has a single write port and
//   each step writes a texel pair, so a step occupies the store in each of its states.
// Reset and restart: a clearing pass writes each entry's address mod 256 into
//   the store, one entry per cycle; in_ready stays low meanwhile.
//   APB writes are taken at any time.
// Stall: the result waits in an output register; a new command is taken
//   once that register is empty or being drained in the same cycle.

module procedural_noise_texture_gen_unit
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // APB configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pntg_pkg::PADDR_W-1:0]         paddr,
    input  logic [pntg_pkg::PDATA_W-1:0]         pwdata,
    output logic [pntg_pkg::PDATA_W-1:0]         prdata,
    output logic                                 pready,
    // command channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           mode,
    input  logic [pntg_pkg::STORE_AW-1:0]        read_index,
    // result channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 write_valid,
    output logic [pntg_pkg::STORE_AW-1:0]        write_index,
    output logic [pntg_pkg::STORE_AW-1:0]        mirror_index,
    output logic [pntg_pkg::TEXEL_W-1:0]         texel_value,
    output logic [pntg_pkg::TEXEL_W-1:0]         read_value,
    output logic                                 finished
);

    logic [pntg_pkg::TEXEL_W-1:0] seed_reg, seed_next;
    logic                         apb_wr;
    pntg_pkg::cmd_t               ctrl_cmd;
    pntg_pkg::sts_t               dp_sts;
    logic [2:0]                   store_wr_srcs;
    logic [pntg_pkg::STORE_AW-1:0] mirror_expect;

    // APB: zero wait states; address bit 2 selects the register slot,
    // only slot 0 (accum_seed) exists.
    assign pready = 1'b1;
    assign apb_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        seed_next = seed_reg;
        if (apb_wr && (paddr[2] == pntg_pkg::REG_ACCUM_SEED))
            seed_next = pwdata[pntg_pkg::TEXEL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seed_reg <= pntg_pkg::SEED_RESET;
        else
            seed_reg <= seed_next;
    end

    assign prdata = (paddr[2] == pntg_pkg::REG_ACCUM_SEED) ?
                    {{(pntg_pkg::PDATA_W-pntg_pkg::TEXEL_W){1'b0}}, seed_reg} : '0;

    pntg_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .mode      (mode),
        .out_ready (out_ready),
        .sts       (dp_sts),
        .in_ready  (in_ready),
        .cmd       (ctrl_cmd)
    );

    pntg_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (ctrl_cmd),
        .read_index   (read_index),
        .accum_seed   (seed_reg),
        .out_ready    (out_ready),
        .sts          (dp_sts),
        .out_valid    (out_valid),
        .write_valid  (write_valid),
        .write_index  (write_index),
        .mirror_index (mirror_index),
        .texel_value  (texel_value),
        .read_value   (read_value),
        .finished     (finished)
    );

    // store write sources and expected mirror address, for the checks below
    assign store_wr_srcs = {ctrl_cmd.clr_write, ctrl_cmd.gen_calc, ctrl_cmd.gen_mirror};
    assign mirror_expect = write_index ^ pntg_pkg::MIRROR_MASK;

    // only one store write source per cycle
    `PNTG_ASSERT_IMP(a_one_writer, clk, rst_n, 1'b1, $onehot0(store_wr_srcs))
    // no command taken during the clearing pass
    `PNTG_ASSERT_IMP(a_no_accept_in_clear, clk, rst_n, in_ready, !ctrl_cmd.clr_write)
    // primary write is always followed by its mirror write
    `PNTG_ASSERT_NXT(a_calc_then_mirror, clk, rst_n, ctrl_cmd.gen_calc, ctrl_cmd.gen_mirror)
    // reported mirror address matches the primary address
    `PNTG_ASSERT_IMP(a_mirror_addr, clk, rst_n, out_valid && write_valid, mirror_index == mirror_expect)

endmodule
